/* rtl/core/sorted_table_search_top_assert.svh */
// Assertion macros for the sorted table search top level.
`ifndef SORTED_TABLE_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define STS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sts_pkg.sv */
// Shared types and constants of the sorted table search block.
package sts_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 16;

  localparam logic [4:0] ENTRY_COUNT_RESET = 5'd15;

  // register index taken from paddr[2]
  localparam logic CFG_ENTRY_COUNT = 1'b0;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SORT   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_SORTED  = 2'd1;
  localparam logic [1:0] ST_FOUND   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* rtl/core/sts_cmp.sv */
// Shared signed 32-bit comparator used by both sort and search.
module sts_cmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output sts_pkg::cmp_res_t  res_o
);

  assign res_o.lt = a_i < b_i;
  assign res_o.eq = a_i == b_i;

endmodule

/* rtl/core/sts_seq.sv */
// Sequencer with table memory: write, bubble sort and binary search.
module sts_seq #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         entry_count_i,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [1:0]         op_i,
  input  logic [3:0]         index_i,
  input  logic [31:0]        value_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        rdata_o,
  output logic [31:0]        opnd_o,
  input  sts_pkg::cmp_res_t  cmp_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_PASS_START = 9'b000000010,
    S_PASS_LOAD  = 9'b000000100,
    S_PASS_RD    = 9'b000001000,
    S_PASS_CMP   = 9'b000010000,
    S_PASS_END   = 9'b000100000,
    S_SRCH_ADDR  = 9'b001000000,
    S_SRCH_CMP   = 9'b010000000,
    S_DONE       = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]   idx_q, idx_d, last_q, last_d;
  logic            moved_q, moved_d;
  logic [31:0]     opnd_q, opnd_d;
  logic [1:0]      status_q, status_d;
  logic            m_valid_q, m_valid_d;
  logic [1:0]      m_status_q, m_status_d;

  logic [CW-1:0]   used_cnt, mid, idx_nxt;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata;
  logic [31:0]     mem [TABLE_DEPTH];
  logic [31:0]     rdata_q;

  assign used_cnt = (32'(entry_count_i) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                        : CW'(entry_count_i);
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_nxt  = idx_q + CW'(1);

  always_comb begin
    state_d    = state_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    idx_d      = idx_q;
    last_d     = last_q;
    moved_d    = moved_q;
    opnd_d     = opnd_q;
    status_d   = status_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    m_status_d = m_status_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = opnd_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          case (op_i)
            sts_pkg::OP_WRITE: begin
              mem_we    = 32'(index_i) < TABLE_DEPTH;
              mem_waddr = AW'(index_i);
              mem_wdata = value_i;
              status_d  = sts_pkg::ST_WRITTEN;
              state_d   = S_DONE;
            end
            sts_pkg::OP_SORT: begin
              status_d = sts_pkg::ST_SORTED;
              if (used_cnt < CW'(2)) begin
                state_d = S_DONE;
              end else begin
                last_d  = used_cnt - CW'(1);
                state_d = S_PASS_START;
              end
            end
            sts_pkg::OP_SEARCH: begin
              lo_d    = '0;
              hi_d    = used_cnt;
              opnd_d  = value_i;
              state_d = S_SRCH_ADDR;
            end
            default: begin
              status_d = sts_pkg::ST_MISSING;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_PASS_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        idx_d     = '0;
        moved_d   = 1'b0;
        state_d   = S_PASS_LOAD;
      end
      S_PASS_LOAD: begin
        opnd_d  = rdata_q;
        state_d = S_PASS_RD;
      end
      S_PASS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_nxt[AW-1:0];
        state_d   = S_PASS_CMP;
      end
      S_PASS_CMP: begin
        // smaller word settles at idx, larger one is carried on
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        if (cmp_i.lt) begin
          mem_wdata = rdata_q;
          moved_d   = 1'b1;
        end else begin
          mem_wdata = opnd_q;
          opnd_d    = rdata_q;
        end
        idx_d   = idx_nxt;
        state_d = (idx_nxt == last_q) ? S_PASS_END : S_PASS_RD;
      end
      S_PASS_END: begin
        mem_we    = 1'b1;
        mem_waddr = last_q[AW-1:0];
        mem_wdata = opnd_q;
        if (!moved_q || last_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          last_d  = last_q - CW'(1);
          state_d = S_PASS_START;
        end
      end
      S_SRCH_ADDR: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid[AW-1:0];
          state_d   = S_SRCH_CMP;
        end else begin
          status_d = sts_pkg::ST_MISSING;
          state_d  = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (cmp_i.eq) begin
          status_d = sts_pkg::ST_FOUND;
          state_d  = S_DONE;
        end else begin
          if (cmp_i.lt) begin
            lo_d = mid + CW'(1);
          end else begin
            hi_d = mid;
          end
          state_d = S_SRCH_ADDR;
        end
      end
      S_DONE: begin
        // hold here until the output register is free
        if (!m_valid_q || m_ready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lo_q      <= '0;
      hi_q      <= '0;
      idx_q     <= '0;
      last_q    <= '0;
      moved_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      idx_q     <= idx_d;
      last_q    <= last_d;
      moved_q   <= moved_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q     <= opnd_d;
    status_q   <= status_d;
    m_status_q <= m_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign s_ready_o = state_q == S_IDLE;
  assign m_valid_o = m_valid_q;
  assign status_o  = m_status_q;
  assign rdata_o   = rdata_q;
  assign opnd_o    = opnd_q;

endmodule

/* rtl/core/sorted_table_search_top.sv */
// Sorted table search top level: stream ports, APB register, sequencer, comparator.
// Search: binary search, at most 5 probes at table depth 16.
// Sort: up to n-1 passes over the n entries in use, stops after a swap-free pass.
// Each table read goes through the single registered read port; sort and search share the one comparator.
// Next item is taken once the previous result sits in the output register.
// Reset (async, active low) idles the sequencer, empties the output, entry_count = 15.
`include "sorted_table_search_top_assert.svh"

module sorted_table_search_top #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] entry_index, [35:4] data_value, [39:36] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] status, [7:2] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]        entry_count_q;
  logic              cfg_we;
  logic [1:0]        status;
  logic [31:0]       rdata, opnd;
  sts_pkg::cmp_res_t cmp_res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[2] == sts_pkg::CFG_ENTRY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= sts_pkg::ENTRY_COUNT_RESET;
    end else if (cfg_we) begin
      entry_count_q <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == sts_pkg::CFG_ENTRY_COUNT) ? {27'd0, entry_count_q} : '0;

  sts_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_count_i(entry_count_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .op_i         (s_axis_tuser),
    .index_i      (s_axis_tdata[3:0]),
    .value_i      (s_axis_tdata[35:4]),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .status_o     (status),
    .rdata_o      (rdata),
    .opnd_o       (opnd),
    .cmp_i        (cmp_res)
  );

  sts_cmp u_cmp (
    .a_i  (rdata),
    .b_i  (opnd),
    .res_o(cmp_res)
  );

  assign m_axis_tdata = {6'd0, status};

  // an accepted word always leaves the sequencer busy in the next cycle
  `STS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "input ready right after an accepted word")

  // a result only appears as the sequencer leaves its busy phase
  `STS_ASSERT_IMPL(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready),
                   "result appeared while sequencer was idle")

endmodule

/* tb/sv/tb_sorted_table_search_top.sv */
// Self-checking testbench for sorted_table_search_top: stream traffic, APB entry count.
module tb_sorted_table_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam logic [1:0]  OP_NONE     = 2'd3;   // unassigned opcode, reports not found
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_AT     = 300;    // result count that starts the long stall
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 97;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  // Tracks table contents and entry count, queues the status each word should produce.
  class status_scoreboard;
    logic signed [31:0] entries[DEPTH];
    logic [4:0]         entry_count;
    logic [1:0]         status_q[$];
    int unsigned        mismatches, checked, sorts, hits, misses;

    function new();
      entry_count = sts_pkg::ENTRY_COUNT_RESET;
      foreach (entries[k]) entries[k] = '0;
    endfunction

    function int unsigned used_count();
      return (entry_count > DEPTH) ? DEPTH : entry_count;
    endfunction

    function void bubble_sort();
      int n, last, i;
      logic signed [31:0] t;
      bit moved;
      n = used_count();
      for (last = n - 1; last >= 1; last--) begin
        moved = 1'b0;
        for (i = 0; i < last; i++) begin
          if (entries[i+1] < entries[i]) begin
            t            = entries[i];
            entries[i]   = entries[i+1];
            entries[i+1] = t;
            moved        = 1'b1;
          end
        end
        if (!moved) break;
      end
    endfunction

    function bit key_present(logic signed [31:0] key);
      int lo, hi, mid;
      lo = 0;
      hi = used_count();
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == key) return 1'b1;
        if (entries[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return 1'b0;
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] idx, logic signed [31:0] val);
      logic [1:0] st;
      case (op)
        sts_pkg::OP_WRITE: begin
          entries[idx] = val;
          st = sts_pkg::ST_WRITTEN;
        end
        sts_pkg::OP_SORT: begin
          bubble_sort();
          sorts++;
          st = sts_pkg::ST_SORTED;
        end
        sts_pkg::OP_SEARCH: begin
          st = key_present(val) ? sts_pkg::ST_FOUND : sts_pkg::ST_MISSING;
          if (st == sts_pkg::ST_FOUND) hits++;
          else misses++;
        end
        default: st = sts_pkg::ST_MISSING;
      endcase
      status_q.push_back(st);
    endfunction

    function void check_status(logic [1:0] got);
      logic [1:0] want;
      checked++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with nothing pending, status %0d", got);
        return;
      end
      want = status_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d status expected %0d got %0d", checked, want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [3:0] entry_index, [35:4] data_value, [39:36] zero
  logic [1:0]  s_axis_tuser;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [1:0] status, [7:2] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sorted_table_search_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  status_scoreboard sb = new();
  bit          tx_burst;
  int unsigned words_sent;
  int unsigned cycles;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender: entered just after the previous accept; valid is lowered only for a real gap.
  task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                           input logic signed [31:0] val);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, val, idx};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, idx, val);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [4:0] count);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sts_pkg::CFG_ENTRY_COUNT, 2'b00};
    pwdata  <= {27'($urandom()), count};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.entry_count = count;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 4))
           0: return S32_MIN;
           1: return S32_MAX;
           2: return 32'sd0;
           3: return -32'sd1;
           default: return 32'sd1;
         endcase
      1, 2: return $signed($urandom_range(0, 40)) - 32'sd20;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] e;
    e = sb.entries[$urandom_range(0, DEPTH - 1)];
    case ($urandom_range(0, 3))
      0, 1: return e;
      2: return e + (($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1);
      default: return pick_value();
    endcase
  endfunction

  // Load some entries, sort, search; then a loose mix with a little noise.
  task automatic run_phase(input int unsigned n_items);
    int unsigned done, loads, finds, r;
    done  = 0;
    loads = $urandom_range(4, 20);
    finds = $urandom_range(10, 30);
    repeat (loads) begin
      send_word(sts_pkg::OP_WRITE, 4'($urandom()), pick_value());
      done++;
    end
    send_word(sts_pkg::OP_SORT, 4'($urandom()), $urandom());
    done++;
    repeat (finds) begin
      send_word(sts_pkg::OP_SEARCH, 4'($urandom()), pick_key());
      done++;
    end
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_word(sts_pkg::OP_WRITE, 4'($urandom()), pick_value());
      else if (r < 39) send_word(sts_pkg::OP_SORT, 4'($urandom()), $urandom());
      else if (r < 44) send_word(OP_NONE, 4'($urandom()), $urandom());
      else send_word(sts_pkg::OP_SEARCH, 4'($urandom()), pick_key());
      done++;
    end
  endtask

  // Receiver with random back-pressure, burst stretches and one long stall.
  initial begin : result_sink
    int unsigned gap, got;
    bit rx_burst;
    got      = 0;
    rx_burst = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = rx_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_status(m_axis_tdata[1:0]);
      got++;
      if (got % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      if (got == HOLD_AT) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [4:0] count_plan[10];
    count_plan    = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd20, 5'd8, 5'd16, 5'd3, 5'd15};
    cycles        = 0;
    words_sent    = 0;
    tx_burst      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sts_pkg::OP_WRITE;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill every entry (extremes included), sort 15 of them, probe.
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: send_word(sts_pkg::OP_WRITE, 4'(i), S32_MAX);
        3: send_word(sts_pkg::OP_WRITE, 4'(i), S32_MIN);
        5: send_word(sts_pkg::OP_WRITE, 4'(i), -32'sd1);
        9: send_word(sts_pkg::OP_WRITE, 4'(i), 32'sd0);
        default: send_word(sts_pkg::OP_WRITE, 4'(i), 32'sd1000 - 32'(i) * 32'sd77);
      endcase
    end
    send_word(sts_pkg::OP_SORT,   4'hf, 32'hffff_ffff);
    send_word(sts_pkg::OP_SEARCH, 4'h0, S32_MIN);
    send_word(sts_pkg::OP_SEARCH, 4'h0, S32_MAX);
    send_word(sts_pkg::OP_SEARCH, 4'h0, 32'sd0);
    send_word(sts_pkg::OP_SEARCH, 4'h0, 32'sd12345);
    send_word(sts_pkg::OP_SEARCH, 4'h0, sb.entries[15]);   // outside the 15 in use
    send_word(OP_NONE,            4'hf, 32'hffff_ffff);
    send_word(sts_pkg::OP_SORT,   4'h0, 32'h0);            // already ordered, one pass

    foreach (count_plan[p]) begin
      drain();
      write_entry_count(count_plan[p]);
      tx_burst = (p % 3 == 0);
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Run: %0d words, %0d results checked, %0d sorts, %0d keys found, %0d missed",
             words_sent, sb.checked, sb.sorts, sb.hits, sb.misses);
    $display("Entry counts swept 0, 1, 2, 3, 8, 15, 16, 20, 31; one long output stall.");
    if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.status_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
